@@ src/tcgp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table cell grid placement package
// Shared sizes, opcodes and transaction types for the placement block.
// ----------------------------------------------------------------------------
package tcgp_pkg;

    // Grid dimensions.
    localparam int MAX_ROWS  = 256;
    localparam int MAX_COLS  = 64;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_CNT_W = ROW_W + 1;
    localparam int COL_CNT_W = COL_W + 1;

    // Command opcodes.
    localparam logic [2:0] OP_START_TABLE = 3'd0;
    localparam logic [2:0] OP_START_ROW   = 3'd1;
    localparam logic [2:0] OP_ROW_CELL    = 3'd2;
    localparam logic [2:0] OP_BARE_CELL   = 3'd3;
    localparam logic [2:0] OP_END_TABLE   = 3'd4;

    // Command transaction.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [9:0]  col_span_in;
        logic [15:0] row_span_in;
    } t_in;

    // Result transaction.
    typedef struct packed {
        logic       is_totals;
        logic [7:0] cell_row;
        logic [5:0] cell_col;
        logic [6:0] col_span_out;
        logic [8:0] row_span_out;
        logic [8:0] total_rows;
        logic [6:0] total_cols;
    } t_out;

endpackage

@@ src/tcgp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tcgp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/table_cell_grid_placement.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table cell grid placement
// Places table cells on a row-by-column occupancy grid held in a memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Start table, start
// row, bare cell and end table, and a row cell with no open row, never raise
// busy; a bare cell or end table result strobes on the next cycle. For a row
// cell the occupancy row word is read in the cycle of acceptance, the free
// column (if any) is found and the first row is written in the next cycle
// (the result strobes in the cycle after that), and every further spanned
// row is written in turn through the single write port of the occupancy
// memory. Results strobe for one cycle and cannot be stalled.
// After reset the grid reads as empty at once through per-row valid bits;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module table_cell_grid_placement (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  tcgp_pkg::t_in  i_cmd,
    output logic         o_strobe,
    output tcgp_pkg::t_out o_result
);
    import tcgp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FIND = 2'd1;
    localparam logic [1:0] S_WR   = 2'd2;

    localparam logic [MAX_COLS-1:0] ALL_ONES = {MAX_COLS{1'b1}};

    // Control state.
    logic [1:0]           r_state, n_state;
    logic [ROW_CNT_W-1:0] r_row_cnt, n_row_cnt;
    logic [ROW_W-1:0]     r_cur_row, n_cur_row;
    logic [COL_CNT_W-1:0] r_next_col, n_next_col;
    logic [COL_CNT_W-1:0] r_col_cnt, n_col_cnt;
    logic                 r_row_open, n_row_open;
    logic                 r_strobe, n_strobe;
    logic [MAX_ROWS-1:0]  r_vld;
    logic                 r_rd_vld;

    // Working registers for the current row cell.
    t_in                  r_cmd;
    t_out                 r_res, n_res;
    logic [MAX_COLS-1:0]  r_mask, n_mask;
    logic [ROW_W-1:0]     r_wr_row, n_wr_row;
    logic [ROW_CNT_W-1:0] r_rows_left, n_rows_left;

    // Memory port signals.
    logic                 ram_we;
    logic [ROW_W-1:0]     ram_waddr;
    logic [MAX_COLS-1:0]  ram_wdata;
    logic [ROW_W-1:0]     ram_raddr;
    logic [MAX_COLS-1:0]  ram_q;

    // Search and clipping.
    logic                 accept;
    logic                 clear_grid;
    logic [MAX_COLS-1:0]  word;
    logic [MAX_COLS-1:0]  free;
    logic [MAX_COLS-1:0]  lowbit;
    logic [COL_W-1:0]     col;
    logic [9:0]           cs_req;
    logic [COL_CNT_W-1:0] cs_lim;
    logic [COL_CNT_W-1:0] cs;
    logic [15:0]          rs_req;
    logic [ROW_CNT_W-1:0] rs_lim;
    logic [ROW_CNT_W-1:0] rs;
    logic [COL_CNT_W-1:0] col_end;
    logic [MAX_COLS-1:0]  mask;

    assign accept     = start && !busy;
    assign clear_grid = accept && (i_cmd.opcode == OP_START_TABLE);
    assign busy       = (r_state != S_IDLE);
    assign o_strobe   = r_strobe;
    assign o_result   = r_res;

    // Occupancy memory.
    tcgp_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // A row never written since the last clear reads as empty.
    assign word = r_rd_vld ? ram_q : '0;

    // First free column at or after the running column.
    always_comb begin
        free   = ~word & (ALL_ONES << r_next_col);
        lowbit = free & (~free + 1'b1);
        col    = '0;
        for (int i = 0; i < MAX_COLS; i++) begin
            if (lowbit[i]) begin
                col = col | COL_W'(i);
            end
        end
    end

    // Span clipping and the covered column mask.
    always_comb begin
        cs_req  = (r_cmd.col_span_in == '0) ? 10'd1 : r_cmd.col_span_in;
        cs_lim  = COL_CNT_W'(MAX_COLS) - {1'b0, col};
        cs      = (cs_req > {{(10-COL_CNT_W){1'b0}}, cs_lim}) ? cs_lim
                                                               : cs_req[COL_CNT_W-1:0];
        rs_req  = (r_cmd.row_span_in == '0) ? 16'd1 : r_cmd.row_span_in;
        rs_lim  = ROW_CNT_W'(MAX_ROWS) - {1'b0, r_cur_row};
        rs      = (rs_req > {{(16-ROW_CNT_W){1'b0}}, rs_lim}) ? rs_lim
                                                               : rs_req[ROW_CNT_W-1:0];
        col_end = {1'b0, col} + cs;
        mask    = (ALL_ONES >> (COL_CNT_W'(MAX_COLS) - cs)) << col;
    end

    // Read address: the current row on acceptance, the next row while marking.
    always_comb begin
        case (r_state)
            S_IDLE:  ram_raddr = r_cur_row;
            S_FIND:  ram_raddr = r_cur_row + 1'b1;
            S_WR:    ram_raddr = r_wr_row + 1'b1;
            default: ram_raddr = r_cur_row;
        endcase
    end

    // Command sequencer.
    always_comb begin
        n_state     = r_state;
        n_row_cnt   = r_row_cnt;
        n_cur_row   = r_cur_row;
        n_next_col  = r_next_col;
        n_col_cnt   = r_col_cnt;
        n_row_open  = r_row_open;
        n_strobe    = 1'b0;
        n_res       = r_res;
        n_mask      = r_mask;
        n_wr_row    = r_wr_row;
        n_rows_left = r_rows_left;
        ram_we      = 1'b0;
        ram_waddr   = r_wr_row;
        ram_wdata   = word | r_mask;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.opcode)
                        OP_START_TABLE: begin
                            n_row_cnt  = '0;
                            n_cur_row  = '0;
                            n_next_col = '0;
                            n_col_cnt  = '0;
                            n_row_open = 1'b0;
                        end
                        OP_START_ROW: begin
                            if (r_row_cnt >= ROW_CNT_W'(MAX_ROWS)) begin
                                n_row_open = 1'b0;
                            end else begin
                                n_cur_row  = r_row_cnt[ROW_W-1:0];
                                n_row_cnt  = r_row_cnt + 1'b1;
                                n_next_col = '0;
                                n_row_open = 1'b1;
                            end
                        end
                        OP_ROW_CELL: begin
                            if (r_row_open) begin
                                n_state = S_FIND;
                            end
                        end
                        OP_BARE_CELL: begin
                            n_row_open = 1'b0;
                            if (r_row_cnt < ROW_CNT_W'(MAX_ROWS)) begin
                                n_strobe           = 1'b1;
                                n_res              = '0;
                                n_res.cell_row     = r_row_cnt[ROW_W-1:0];
                                n_res.col_span_out = 7'd1;
                                n_res.row_span_out = 9'd1;
                                n_row_cnt          = r_row_cnt + 1'b1;
                                if (r_col_cnt == '0) begin
                                    n_col_cnt = COL_CNT_W'(1);
                                end
                            end
                        end
                        OP_END_TABLE: begin
                            n_row_open       = 1'b0;
                            n_strobe         = 1'b1;
                            n_res            = '0;
                            n_res.is_totals  = 1'b1;
                            n_res.total_rows = (r_row_cnt == '0) ? 9'd1 : r_row_cnt;
                            n_res.total_cols = (r_col_cnt == '0) ? 7'd1 : r_col_cnt;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_FIND: begin
                if (free == '0) begin
                    // Row full: this and every later cell of the row is dropped.
                    n_next_col = COL_CNT_W'(MAX_COLS);
                    n_state    = S_IDLE;
                end else begin
                    // Place the cell and mark its first row.
                    ram_we             = 1'b1;
                    ram_waddr          = r_cur_row;
                    ram_wdata          = word | mask;
                    n_mask             = mask;
                    n_next_col         = col_end;
                    if (col_end > r_col_cnt) begin
                        n_col_cnt = col_end;
                    end
                    n_strobe           = 1'b1;
                    n_res              = '0;
                    n_res.cell_row     = r_cur_row;
                    n_res.cell_col     = col;
                    n_res.col_span_out = cs;
                    n_res.row_span_out = rs;
                    n_wr_row           = r_cur_row + 1'b1;
                    n_rows_left        = rs - 1'b1;
                    n_state            = (rs > ROW_CNT_W'(1)) ? S_WR : S_IDLE;
                end
            end

            S_WR: begin
                // Mark one further spanned row per cycle.
                ram_we      = 1'b1;
                ram_waddr   = r_wr_row;
                n_wr_row    = r_wr_row + 1'b1;
                n_rows_left = r_rows_left - 1'b1;
                if (r_rows_left == ROW_CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_row_cnt  <= '0;
            r_cur_row  <= '0;
            r_next_col <= '0;
            r_col_cnt  <= '0;
            r_row_open <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row_cnt  <= n_row_cnt;
            r_cur_row  <= n_cur_row;
            r_next_col <= n_next_col;
            r_col_cnt  <= n_col_cnt;
            r_row_open <= n_row_open;
            r_strobe   <= n_strobe;
        end
    end

    // Per-row valid bits: cleared at once by reset and start table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_grid) begin
            r_vld <= '0;
        end else if (ram_we) begin
            r_vld[ram_waddr] <= 1'b1;
        end
    end

    // Valid bit that travels with the memory read data.
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[ram_raddr];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_res       <= n_res;
        r_mask      <= n_mask;
        r_wr_row    <= n_wr_row;
        r_rows_left <= n_rows_left;
    end

    // A result only follows an accepted command or a cycle of row cell work.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without a command in flight");

    // Totals are never reported below one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.is_totals) |->
            (o_result.total_rows != '0 && o_result.total_cols != '0))
        else $error("totals result with a zero count");

    // A placed cell stays inside the grid.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.is_totals) |->
            (({2'b0, o_result.cell_col} + {1'b0, o_result.col_span_out})
                 <= 8'(MAX_COLS) &&
             ({2'b0, o_result.cell_row} + {1'b0, o_result.row_span_out})
                 <= 10'(MAX_ROWS)))
        else $error("placed cell extends past the grid");

    // The occupancy memory is only written while a row cell is in progress.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("occupancy write while idle");

endmodule

@@ verif/table_cell_grid_placement_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table cell grid placement testbench
// Drives command transactions into the placement block with random gaps on
// the command side, predicts every placement and totals result from its own
// model of the occupancy grid, and checks each strobed result in order.
// ----------------------------------------------------------------------------
module table_cell_grid_placement_test;

    import tcgp_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int ITEM_TARGET  = 1350;
    localparam int CYCLE_LIMIT  = 5000000;
    localparam int SETTLE_CYCLES = 20;

    // Prediction of the grid and the ordered store of pending results.
    class placement_scoreboard;
        t_out                 pending_results[$];
        int                   errors;
        int                   results_seen;
        logic [MAX_COLS-1:0]  occupancy [MAX_ROWS];
        logic [ROW_CNT_W-1:0] row_count;
        logic [ROW_W-1:0]     current_row;
        logic [COL_CNT_W-1:0] next_col;
        logic [COL_CNT_W-1:0] col_count;
        bit                   row_open;

        function new();
            errors = 0;
            results_seen = 0;
            clear_grid();
        endfunction

        function void clear_grid();
            foreach (occupancy[r]) occupancy[r] = '0;
            row_count   = '0;
            current_row = '0;
            next_col    = '0;
            col_count   = '0;
            row_open    = 1'b0;
        endfunction

        // Applies one accepted command; returns 1 when it clears the grid, opens a row or queues a result.
        function bit note_command(t_in cmd);
            t_out                placed;
            int                  col;
            int                  cs;
            int                  rs;
            logic [MAX_COLS-1:0] mask;
            bit                  acted;
            placed = '0;
            acted  = 1'b0;
            case (cmd.opcode)
                OP_START_TABLE: begin
                    clear_grid();
                    acted = 1'b1;
                end
                OP_START_ROW: begin
                    // At the row limit the row is refused and stays closed.
                    if (row_count >= MAX_ROWS) begin
                        row_open = 1'b0;
                    end else begin
                        current_row = row_count[ROW_W-1:0];
                        row_count   = row_count + 1'b1;
                        next_col    = '0;
                        row_open    = 1'b1;
                        acted       = 1'b1;
                    end
                end
                OP_ROW_CELL: begin
                    if (row_open) begin
                        col = next_col;
                        while (col < MAX_COLS && occupancy[current_row][col])
                            col++;
                        if (col >= MAX_COLS) begin
                            // Row full: this and all later cells of the row drop.
                            next_col = COL_CNT_W'(MAX_COLS);
                        end else begin
                            cs = (cmd.col_span_in == 0) ? 1 : int'(cmd.col_span_in);
                            rs = (cmd.row_span_in == 0) ? 1 : int'(cmd.row_span_in);
                            if (cs > MAX_COLS - col)
                                cs = MAX_COLS - col;
                            if (rs > MAX_ROWS - int'(current_row))
                                rs = MAX_ROWS - int'(current_row);
                            mask = '0;
                            for (int c = col; c < col + cs; c++)
                                mask[c] = 1'b1;
                            for (int rr = current_row; rr < int'(current_row) + rs; rr++)
                                occupancy[rr] = occupancy[rr] | mask;
                            if (col + cs > int'(col_count))
                                col_count = COL_CNT_W'(col + cs);
                            next_col = COL_CNT_W'(col + cs);
                            placed.cell_row     = current_row;
                            placed.cell_col     = COL_W'(col);
                            placed.col_span_out = COL_CNT_W'(cs);
                            placed.row_span_out = ROW_CNT_W'(rs);
                            pending_results.push_back(placed);
                            acted = 1'b1;
                        end
                    end
                end
                OP_BARE_CELL: begin
                    // A bare cell owns a new row but leaves the grid untouched.
                    row_open = 1'b0;
                    if (row_count < MAX_ROWS) begin
                        placed.cell_row     = row_count[ROW_W-1:0];
                        placed.col_span_out = COL_CNT_W'(1);
                        placed.row_span_out = ROW_CNT_W'(1);
                        pending_results.push_back(placed);
                        if (col_count == 0)
                            col_count = COL_CNT_W'(1);
                        row_count = row_count + 1'b1;
                        acted = 1'b1;
                    end
                end
                OP_END_TABLE: begin
                    row_open = 1'b0;
                    placed.is_totals  = 1'b1;
                    placed.total_rows = (row_count == 0) ? ROW_CNT_W'(1) : row_count;
                    placed.total_cols = (col_count == 0) ? COL_CNT_W'(1) : col_count;
                    pending_results.push_back(placed);
                    acted = 1'b1;
                end
                default: ;
            endcase
            return acted;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("ERROR: result %0d: %s", results_seen, what);
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        // Compares a strobed result with the oldest pending one.
        task check_result(t_out got);
            t_out want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result strobed with none pending");
            end else begin
                want = pending_results.pop_front();
                check_field("is_totals", 16'(got.is_totals), 16'(want.is_totals));
                check_field("cell_row", 16'(got.cell_row), 16'(want.cell_row));
                check_field("cell_col", 16'(got.cell_col), 16'(want.cell_col));
                check_field("col_span_out", 16'(got.col_span_out), 16'(want.col_span_out));
                check_field("row_span_out", 16'(got.row_span_out), 16'(want.row_span_out));
                check_field("total_rows", 16'(got.total_rows), 16'(want.total_rows));
                check_field("total_cols", 16'(got.total_cols), 16'(want.total_cols));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_cmd;
    logic o_strobe;
    t_out o_result;

    placement_scoreboard scoreboard = new();
    int effective_items = 0;
    int cycle_count = 0;
    int idle_pct = 15;

    table_cell_grid_placement uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Clock generation.
    always #CLK_HALF i_clk = ~i_clk;

    // Watch both sides of the block at every rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            if (scoreboard.note_command(i_cmd))
                effective_items++;
        end
        if (i_rst_n && o_strobe)
            scoreboard.check_result(o_result);
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Presents one command, with an optional gap first, and waits until it is taken.
    task automatic send_cmd(input logic [2:0] op, input logic [9:0] cs,
                            input logic [15:0] rs);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= '{opcode: op, col_span_in: cs, row_span_in: rs};
        do @(posedge i_clk); while (busy);
    endtask

    // Holds commands off until every pending result has been strobed. The
    // first edge lets the monitor note the command taken at the current edge.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (scoreboard.pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Column spans are mostly small, sometimes anything the field can hold.
    function automatic logic [9:0] pick_col_span();
        if ($urandom_range(0, 7) == 0)
            return 10'($urandom_range(0, 1023));
        return 10'($urandom_range(0, 4));
    endfunction

    // Row spans are mostly one to three rows; a long span keeps the block busy for each spanned row.
    function automatic logic [15:0] pick_row_span();
        if ($urandom_range(0, 11) == 0)
            return 16'($urandom());
        return 16'($urandom_range(0, 3));
    endfunction

    initial begin
        int  kind;
        int  phase;
        int  n_rows;
        int  n_cells;
        bit  filled;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        phase   = 0;
        filled  = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty totals, cells without an open row, clipping,
        // full rows, spans from the rows above, bare cells and unknown opcodes.
        send_cmd(OP_END_TABLE, 10'd0, 16'd0);
        send_cmd(OP_ROW_CELL, 10'd1, 16'd1);
        send_cmd(OP_START_TABLE, 10'h3FF, 16'hFFFF);
        send_cmd(OP_START_ROW, 10'd0, 16'd0);
        send_cmd(OP_ROW_CELL, 10'd0, 16'd0);
        send_cmd(OP_ROW_CELL, 10'd2, 16'd3);
        send_cmd(OP_ROW_CELL, 10'd1023, 16'd0);
        send_cmd(OP_ROW_CELL, 10'd1, 16'd1);
        send_cmd(OP_START_ROW, 10'd0, 16'd0);
        send_cmd(OP_ROW_CELL, 10'd1, 16'd1);
        send_cmd(OP_ROW_CELL, 10'd0, 16'hFFFF);
        send_cmd(OP_BARE_CELL, 10'h3FF, 16'hFFFF);
        send_cmd(OP_ROW_CELL, 10'd1, 16'd1);
        send_cmd(3'd5, 10'h3FF, 16'hFFFF);
        send_cmd(3'd6, 10'd0, 16'd0);
        send_cmd(3'd7, 10'h3FF, 16'hFFFF);
        send_cmd(OP_START_ROW, 10'd0, 16'd0);
        send_cmd(OP_ROW_CELL, 10'd64, 16'd1);
        send_cmd(OP_ROW_CELL, 10'd1, 16'd1);
        send_cmd(OP_END_TABLE, 10'h3FF, 16'hFFFF);
        send_cmd(OP_ROW_CELL, 10'd1, 16'd1);
        send_cmd(OP_START_TABLE, 10'd0, 16'd0);
        send_cmd(OP_BARE_CELL, 10'd0, 16'd0);
        send_cmd(OP_END_TABLE, 10'd0, 16'd0);

        // Random part, in three phases of command-side gaps.
        while (effective_items < ITEM_TARGET) begin
            if (phase == 0 && effective_items >= ITEM_TARGET / 3) begin
                wait_for_results();
                phase    = 1;
                idle_pct = 45;
            end else if (phase == 1 && effective_items >= 2 * ITEM_TARGET / 3) begin
                wait_for_results();
                phase    = 2;
                idle_pct = 0;
            end

            if (!filled && effective_items >= ITEM_TARGET / 2) begin
                // Run one table up to the row limit, then knock on it.
                filled = 1'b1;
                send_cmd(OP_START_TABLE, 10'd0, 16'd0);
                repeat (MAX_ROWS + 4) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_cmd(OP_START_ROW, 10'd0, 16'd0);
                        send_cmd(OP_ROW_CELL, pick_col_span(), pick_row_span());
                    end else begin
                        send_cmd(OP_BARE_CELL, 10'($urandom()), 16'($urandom()));
                    end
                end
                send_cmd(OP_START_ROW, 10'd0, 16'd0);
                send_cmd(OP_ROW_CELL, 10'd1, 16'd1);
                send_cmd(OP_BARE_CELL, 10'd0, 16'd0);
                send_cmd(OP_END_TABLE, 10'd0, 16'd0);
            end

            kind = $urandom_range(0, 9);
            case (kind)
                8: begin
                    // Noise: any opcode with any field values.
                    repeat ($urandom_range(1, 8))
                        send_cmd(3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)),
                                 16'($urandom()));
                end
                9: begin
                    // Broken table: a row filled in one cell, cells past the
                    // full row, and cells with no open row.
                    send_cmd(OP_START_ROW, 10'd0, 16'd0);
                    send_cmd(OP_ROW_CELL, 10'($urandom_range(64, 1023)), pick_row_span());
                    repeat ($urandom_range(1, 3))
                        send_cmd(OP_ROW_CELL, pick_col_span(), pick_row_span());
                    send_cmd(OP_BARE_CELL, 10'd0, 16'd0);
                    send_cmd(OP_ROW_CELL, pick_col_span(), pick_row_span());
                    send_cmd(OP_END_TABLE, 10'd0, 16'd0);
                    send_cmd(OP_ROW_CELL, pick_col_span(), pick_row_span());
                end
                default: begin
                    // Well-formed table with random rows, cells and spans.
                    send_cmd(OP_START_TABLE, 10'd0, 16'd0);
                    n_rows = $urandom_range(1, 8);
                    repeat (n_rows) begin
                        send_cmd(OP_START_ROW, 10'd0, 16'd0);
                        n_cells = $urandom_range(1, 6);
                        repeat (n_cells)
                            send_cmd(OP_ROW_CELL, pick_col_span(), pick_row_span());
                        if ($urandom_range(0, 9) == 0)
                            send_cmd(OP_BARE_CELL, 10'd0, 16'd0);
                    end
                    send_cmd(OP_END_TABLE, 10'd0, 16'd0);
                end
            endcase
        end

        // Let the last results drain out, then settle.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (scoreboard.errors == 0 && scoreboard.pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
